### design/crst_pkg.sv
// Shared types, constants and field layouts for the call/return symbol tracer.
package crst_pkg;

	localparam int SYMBOL_SLOTS_DEF = 256;
	localparam int QUEUE_DEPTH = 4;

	localparam int SYMBOL_COUNT_W = 9;
	localparam int TYPE_W = 8;
	localparam int INDEX_W = 8;
	localparam int ADDR_W = 32;
	localparam int DEPTH_W = 16;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FUNCTION_TYPE = 2'd1;

	localparam logic [SYMBOL_COUNT_W-1:0] SYMBOL_COUNT_RESET = 9'd0;
	localparam logic [TYPE_W-1:0] FUNCTION_TYPE_RESET = 8'd18;

	localparam logic [6:0] OPC_JAL = 7'h6f;
	localparam logic [6:0] OPC_JALR = 7'h67;
	localparam logic [19:0] RET_PATTERN = 20'h08067;

	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7fff;
	localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;

	localparam int IN_TDATA_W = 176;
	localparam int OUT_PAD_W = 6;
	localparam int OUT_TDATA_W = 104;

	typedef struct packed {
		logic [ADDR_W-1:0] next_pc;
		logic [ADDR_W-1:0] current_pc;
		logic [31:0] instruction;
		logic [TYPE_W-1:0] symbol_type;
		logic [ADDR_W-1:0] symbol_size;
		logic [ADDR_W-1:0] symbol_start;
		logic [INDEX_W-1:0] entry_index;
	} in_tdata_t;

	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [ADDR_W-1:0] target_pc;
		logic [ADDR_W-1:0] source_pc;
		logic [INDEX_W-1:0] target_index;
		logic target_found;
		logic [INDEX_W-1:0] source_index;
		logic source_found;
		logic signed [DEPTH_W-1:0] call_depth;
	} out_tdata_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_CALL,
		CMD_RETURN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [INDEX_W-1:0] index;
		logic [ADDR_W-1:0] word_a;
		logic [ADDR_W-1:0] word_b;
		logic [TYPE_W-1:0] sym_type;
	} cmd_t;

	typedef struct packed {
		logic [TYPE_W-1:0] sym_type;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] start;
	} sym_entry_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DONE
	} back_state_t;

endpackage

### design/crst_front.sv
// Front end: accepts input requests, classifies them and forwards loads and jumps.
module crst_front (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [crst_pkg::IN_TDATA_W-1:0] s_tdata, // entry_index, symbol_start, symbol_size, symbol_type, instruction, current_pc, next_pc
	input logic s_tuser, // op
	output logic cmd_valid,
	input logic cmd_ready,
	output crst_pkg::cmd_t cmd_data
);
	import crst_pkg::*;

	in_tdata_t fields;
	logic [6:0] opcode;
	logic is_jump;
	logic is_ret;
	logic keep;
	logic accept;
	cmd_t cmd_d;
	logic valid_s1;
	cmd_t cmd_s1;

	assign fields = in_tdata_t'(s_tdata);
	assign opcode = fields.instruction[6:0];
	assign is_jump = (opcode == OPC_JAL) || (opcode == OPC_JALR);
	assign is_ret = (fields.instruction[19:0] == RET_PATTERN);
	assign keep = !s_tuser || is_jump;
	assign s_tready = !valid_s1 || cmd_ready;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		cmd_d = '0;
		if (!s_tuser) begin
			cmd_d.kind = CMD_LOAD;
			cmd_d.index = fields.entry_index;
			cmd_d.word_a = fields.symbol_start;
			cmd_d.word_b = fields.symbol_size;
			cmd_d.sym_type = fields.symbol_type;
		end else begin
			cmd_d.kind = is_ret ? CMD_RETURN : CMD_CALL;
			cmd_d.word_a = fields.current_pc;
			cmd_d.word_b = fields.next_pc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd_data = cmd_s1;

endmodule

### design/crst_fifo.sv
// Short command queue between the front end and the search engine.
module crst_fifo (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input crst_pkg::cmd_t in_data,
	output logic out_valid,
	input logic out_pop,
	output crst_pkg::cmd_t out_data
);
	import crst_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	cmd_t slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic push;
	logic pop;

	assign in_ready = (count_q != NW'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign push = in_valid && in_ready;
	assign pop = out_pop && out_valid;
	assign out_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

### design/crst_back.sv
// Back end: symbol table memory, depth counter, range search and result register.
module crst_back #(
	parameter int SYMBOL_SLOTS = crst_pkg::SYMBOL_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_pop,
	input crst_pkg::cmd_t q_cmd,
	input logic cfg_valid,
	input logic [crst_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [crst_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic m_tvalid,
	input logic m_tready,
	output logic [crst_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic m_tuser
);
	import crst_pkg::*;

	localparam int AW = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
	localparam int CW = $clog2(SYMBOL_SLOTS + 1);

	sym_entry_t mem [SYMBOL_SLOTS];

	logic [SYMBOL_COUNT_W-1:0] sym_count_q;
	logic [TYPE_W-1:0] func_code_q;

	back_state_t state_q;
	back_state_t state_d;
	logic mem_we;
	logic trace_start;
	logic out_load;
	logic out_free;
	logic scan_done;

	logic load_in_range;
	logic [AW-1:0] load_addr;
	sym_entry_t load_entry;

	logic [CW-1:0] limit;
	logic [CW-1:0] issue_q;
	logic issue_more;

	logic rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	sym_entry_t rd_data_s1;

	logic [ADDR_W:0] range_end;
	logic type_ok;
	logic src_hit;
	logic tgt_hit;

	logic ret_q;
	logic [ADDR_W-1:0] pc_q;
	logic [ADDR_W-1:0] npc_q;
	logic signed [DEPTH_W-1:0] depth_q;
	logic src_found_q;
	logic [INDEX_W-1:0] src_idx_q;
	logic tgt_found_q;
	logic [INDEX_W-1:0] tgt_idx_q;

	logic m_tvalid_q;
	out_tdata_t m_tdata_q;
	logic m_tuser_q;
	out_tdata_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_count_q <= SYMBOL_COUNT_RESET;
			func_code_q <= FUNCTION_TYPE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SYMBOL_COUNT: sym_count_q <= cfg_data;
				CFG_FUNCTION_TYPE: func_code_q <= cfg_data[TYPE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(sym_count_q) > SYMBOL_SLOTS) begin
			limit = CW'(SYMBOL_SLOTS);
		end else begin
			limit = CW'(sym_count_q);
		end
	end

	assign load_in_range = 32'(q_cmd.index) < SYMBOL_SLOTS;
	assign load_addr = AW'(q_cmd.index);
	assign load_entry = '{sym_type: q_cmd.sym_type, size: q_cmd.word_b, start: q_cmd.word_a};

	assign issue_more = (state_q == B_SCAN) && (issue_q < limit);
	assign scan_done = (state_q == B_SCAN) && !issue_more && !rd_vld_s1;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		mem_we = 1'b0;
		trace_start = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_cmd.kind == CMD_LOAD) begin
						mem_we = load_in_range;
					end else begin
						trace_start = 1'b1;
						state_d = B_SCAN;
					end
				end
			end
			B_SCAN: begin
				if (scan_done) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[load_addr] <= load_entry;
		end
		if (issue_more) begin
			rd_data_s1 <= mem[issue_q[AW-1:0]];
			rd_idx_s1 <= issue_q[AW-1:0];
		end
	end

	assign range_end = {1'b0, rd_data_s1.start} + {1'b0, rd_data_s1.size};
	assign type_ok = (rd_data_s1.sym_type == func_code_q);
	assign src_hit = type_ok && (pc_q >= rd_data_s1.start) && ({1'b0, pc_q} < range_end);
	assign tgt_hit = type_ok && (npc_q >= rd_data_s1.start) && ({1'b0, npc_q} < range_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
			rd_vld_s1 <= 1'b0;
			depth_q <= '0;
			src_found_q <= 1'b0;
			src_idx_q <= '0;
			tgt_found_q <= 1'b0;
			tgt_idx_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_more;
			if (trace_start) begin
				issue_q <= '0;
				src_found_q <= 1'b0;
				src_idx_q <= '0;
				tgt_found_q <= 1'b0;
				tgt_idx_q <= '0;
				if (q_cmd.kind == CMD_RETURN) begin
					if (depth_q != DEPTH_MIN) begin
						depth_q <= depth_q - 16'sd1;
					end
				end else if (depth_q != DEPTH_MAX) begin
					depth_q <= depth_q + 16'sd1;
				end
			end else begin
				if (issue_more) begin
					issue_q <= issue_q + 1'b1;
				end
				if (rd_vld_s1) begin
					if (!src_found_q && src_hit) begin
						src_found_q <= 1'b1;
						src_idx_q <= INDEX_W'(rd_idx_s1);
					end
					if (!tgt_found_q && tgt_hit) begin
						tgt_found_q <= 1'b1;
						tgt_idx_q <= INDEX_W'(rd_idx_s1);
					end
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (trace_start) begin
			ret_q <= (q_cmd.kind == CMD_RETURN);
			pc_q <= q_cmd.word_a;
			npc_q <= q_cmd.word_b;
		end
		if (out_load) begin
			m_tdata_q <= result;
			m_tuser_q <= ret_q;
		end
	end

	always_comb begin
		result = '0;
		result.call_depth = depth_q;
		result.source_found = src_found_q;
		result.source_index = src_idx_q;
		result.target_found = tgt_found_q;
		result.target_index = tgt_idx_q;
		result.source_pc = pc_q;
		result.target_pc = npc_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == B_SCAN)
		else $error("Table read in flight outside of a search.");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SCAN |-> issue_q <= limit)
		else $error("Search address ran past the symbol count.");

	a_found_slot: assert property (@(posedge clk) disable iff (!arst_n)
		src_found_q |-> 32'(src_idx_q) < SYMBOL_SLOTS)
		else $error("Source match points outside the table.");

	a_depth_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!trace_start |=> $stable(depth_q))
		else $error("Depth changed without a call or return.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == B_DONE)
		else $error("Result raised before its search finished.");

endmodule

### design/call_return_symbol_tracer.sv
// Top level of the call/return symbol tracer.
// Input requests arrive on s_tvalid/s_tready. With s_tuser low a request loads one
// symbol slot (start, size, type byte); with s_tuser high it traces one executed
// instruction. JAL and JALR instructions produce one result on m_tvalid/m_tready:
// call or return in m_tuser, the saturating nesting depth, and the first function
// symbol whose range holds the pc and the next pc. Other instructions produce nothing.
// Registers are to be written on cfg_valid/cfg_ready only while the block is idle; the
// block itself does not enforce this, and cfg_ready is always high. A four-entry queue
// decouples the front end from the search engine. A load is written into the table as
// it leaves the queue. A jump occupies the search engine for a scan of N slots, N being
// the smaller of symbol_count and SYMBOL_SLOTS, since the table memory is read at one
// slot per cycle and both addresses are compared per slot.
// Reset clears the depth to zero, symbol_count to 0 and the function type to 18,
// and empties the queue and the result register; table contents stay undefined.
// While m_tready is low the result is held and the queue keeps taking requests
// until it is full, after which s_tready drops.
module call_return_symbol_tracer #(
	parameter int SYMBOL_SLOTS = crst_pkg::SYMBOL_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [crst_pkg::IN_TDATA_W-1:0] s_tdata, // entry_index, symbol_start, symbol_size, symbol_type, instruction, current_pc, next_pc
	input logic s_tuser, // op
	output logic m_tvalid,
	input logic m_tready,
	output logic [crst_pkg::OUT_TDATA_W-1:0] m_tdata, // call_depth, source_found, source_index, target_found, target_index, source_pc, target_pc
	output logic m_tuser, // is_return
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [crst_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [crst_pkg::CFG_DATA_W-1:0] cfg_data
);
	import crst_pkg::*;

	logic fq_valid;
	logic fq_ready;
	cmd_t fq_cmd;
	logic bq_valid;
	logic bq_pop;
	cmd_t bq_cmd;

	assign cfg_ready = 1'b1;

	crst_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cmd_valid(fq_valid),
		.cmd_ready(fq_ready),
		.cmd_data(fq_cmd)
	);

	crst_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fq_valid),
		.in_ready(fq_ready),
		.in_data(fq_cmd),
		.out_valid(bq_valid),
		.out_pop(bq_pop),
		.out_data(bq_cmd)
	);

	crst_back #(
		.SYMBOL_SLOTS(SYMBOL_SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(bq_valid),
		.q_pop(bq_pop),
		.q_cmd(bq_cmd),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

endmodule

### tb/sv/crst_checker.sv
`timescale 1ns / 1ps
// Testbench request codes and the checker that predicts and compares the tracer's results.
package crst_tb_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TRACE = 1'b1;

endpackage

module crst_checker
	import crst_pkg::*;
	import crst_tb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [IN_TDATA_W-1:0] s_tdata,
	input logic s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic m_tuser,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output int errors,
	output int pending
);

	typedef struct packed {
		logic is_return;
		logic signed [DEPTH_W-1:0] call_depth;
		logic source_found;
		logic [INDEX_W-1:0] source_index;
		logic target_found;
		logic [INDEX_W-1:0] target_index;
		logic [ADDR_W-1:0] source_pc;
		logic [ADDR_W-1:0] target_pc;
	} jump_event_t;

	logic [ADDR_W-1:0] sym_start [SYMBOL_SLOTS_DEF];
	logic [ADDR_W-1:0] sym_size [SYMBOL_SLOTS_DEF];
	logic [TYPE_W-1:0] sym_type [SYMBOL_SLOTS_DEF];
	logic [SYMBOL_COUNT_W-1:0] search_count;
	logic [TYPE_W-1:0] func_type;
	logic signed [DEPTH_W-1:0] depth;
	jump_event_t expected_jumps [$];

	// The range end is formed in one extra bit so that it never wraps.
	function automatic void find_function(input logic [ADDR_W-1:0] addr, output logic hit,
			output logic [INDEX_W-1:0] slot);
		int limit;
		logic [ADDR_W:0] range_end;
		limit = (search_count > SYMBOL_SLOTS_DEF) ? SYMBOL_SLOTS_DEF : int'(search_count);
		hit = 1'b0;
		slot = '0;
		for (int i = 0; i < limit; i++) begin
			range_end = {1'b0, sym_start[i]} + {1'b0, sym_size[i]};
			if (!hit && addr >= sym_start[i] && {1'b0, addr} < range_end &&
					sym_type[i] == func_type) begin
				hit = 1'b1;
				slot = i[INDEX_W-1:0];
			end
		end
	endfunction

	function automatic void compare_field(input string field, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (want !== got) begin
			if (errors < 40)
				$display("%0t ns: %s expected %h actual %h", $time, field, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		in_tdata_t req;
		out_tdata_t res;
		jump_event_t want;
		logic ret;
		if (!arst_n) begin
			search_count = SYMBOL_COUNT_RESET;
			func_type = FUNCTION_TYPE_RESET;
			depth = '0;
			expected_jumps.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_SYMBOL_COUNT: search_count = cfg_data[SYMBOL_COUNT_W-1:0];
				CFG_FUNCTION_TYPE: func_type = cfg_data[TYPE_W-1:0];
				default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				req = s_tdata;
				if (s_tuser == OP_LOAD) begin
					sym_start[req.entry_index] = req.symbol_start;
					sym_size[req.entry_index] = req.symbol_size;
					sym_type[req.entry_index] = req.symbol_type;
				end else if (req.instruction[6:0] == OPC_JAL ||
						req.instruction[6:0] == OPC_JALR) begin
					ret = req.instruction[19:0] == RET_PATTERN;
					if (ret) begin
						if (depth != DEPTH_MIN)
							depth = depth - 16'sd1;
					end else if (depth != DEPTH_MAX) begin
						depth = depth + 16'sd1;
					end
					want.is_return = ret;
					want.call_depth = depth;
					find_function(req.current_pc, want.source_found, want.source_index);
					find_function(req.next_pc, want.target_found, want.target_index);
					want.source_pc = req.current_pc;
					want.target_pc = req.next_pc;
					expected_jumps.push_back(want);
				end
			end
			if (m_tvalid && m_tready) begin
				res = m_tdata;
				if (expected_jumps.size() == 0) begin
					if (errors < 40)
						$display("%0t ns: result expected none actual %h", $time, m_tdata);
					errors++;
				end else begin
					want = expected_jumps.pop_front();
					compare_field("is_return", want.is_return, m_tuser);
					compare_field("call_depth", want.call_depth, res.call_depth);
					compare_field("source_found", want.source_found, res.source_found);
					compare_field("source_index", want.source_index, res.source_index);
					compare_field("target_found", want.target_found, res.target_found);
					compare_field("target_index", want.target_index, res.target_index);
					compare_field("source_pc", want.source_pc, res.source_pc);
					compare_field("target_pc", want.target_pc, res.target_pc);
				end
			end
			pending <= expected_jumps.size();
		end
	end

endmodule

### tb/sv/tb_call_return_symbol_tracer.sv
`timescale 1ns / 1ps
// Testbench top that drives requests into the call/return symbol tracer and reports the verdict.
module tb_call_return_symbol_tracer;
	import crst_pkg::*;
	import crst_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_OFF_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int errors;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;
	logic hold_off;
	int idle_cycles;
	int cur_count;
	logic [TYPE_W-1:0] cur_ftype;

	call_return_symbol_tracer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	crst_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL call_return_symbol_tracer");
				$finish;
			end
		end
	end

	function automatic logic [ADDR_W-1:0] pick_addr();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		2, 3: return $urandom;
		default: return 32'h8000_0000 + $urandom_range(0, 32'h3fff);
		endcase
	endfunction

	task automatic make_req(input int load_pct, output logic op, output in_tdata_t req);
		int kind;
		op = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_TRACE;
		req.entry_index = ($urandom_range(0, 1) != 0) ? INDEX_W'($urandom_range(0, 255))
				: INDEX_W'($urandom_range(0, 15));
		case ($urandom_range(0, 9))
		7: req.symbol_start = $urandom;
		8: req.symbol_start = 32'hffff_ff00 + $urandom_range(0, 255);
		9: req.symbol_start = '0;
		default: req.symbol_start = 32'h8000_0000 + $urandom_range(0, 63) * 32'h100;
		endcase
		case ($urandom_range(0, 9))
		7: req.symbol_size = '0;
		8: req.symbol_size = $urandom;
		9: req.symbol_size = '1;
		default: req.symbol_size = $urandom_range(32'h40, 32'h400);
		endcase
		req.symbol_type = ($urandom_range(0, 9) < 7) ? cur_ftype : TYPE_W'($urandom);
		kind = $urandom_range(0, 99);
		req.instruction = $urandom;
		if (kind < 30)
			req.instruction[6:0] = OPC_JAL;
		else if (kind < 55)
			req.instruction[6:0] = OPC_JALR;
		else if (kind < 80)
			req.instruction[19:0] = RET_PATTERN;
		else if (req.instruction[6:0] == OPC_JAL || req.instruction[6:0] == OPC_JALR)
			req.instruction[4] = ~req.instruction[4];
		req.current_pc = pick_addr();
		req.next_pc = pick_addr();
	endtask

	task automatic send_req(input logic op, input in_tdata_t req);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= req;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic load_slot(input logic [INDEX_W-1:0] slot, input logic [ADDR_W-1:0] start,
			input logic [ADDR_W-1:0] size, input logic [TYPE_W-1:0] sym_type);
		in_tdata_t req;
		logic op;
		make_req(0, op, req);
		req.entry_index = slot;
		req.symbol_start = start;
		req.symbol_size = size;
		req.symbol_type = sym_type;
		send_req(OP_LOAD, req);
	endtask

	task automatic trace_req(input logic [31:0] word, input logic [ADDR_W-1:0] pc,
			input logic [ADDR_W-1:0] npc);
		in_tdata_t req;
		logic op;
		make_req(0, op, req);
		req.instruction = word;
		req.current_pc = pc;
		req.next_pc = npc;
		send_req(OP_TRACE, req);
	endtask

	// Loads and other instructions give no result, so the engine may still be busy
	// when the last expected result has arrived.
	task automatic drain();
		int settle;
		settle = 4 * ((cur_count > SYMBOL_SLOTS_DEF ? SYMBOL_SLOTS_DEF : cur_count) + 6) + 16;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic configure(input int unsigned count, input int unsigned ftype);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SYMBOL_COUNT;
		cfg_data <= count[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_FUNCTION_TYPE;
		cfg_data <= ftype[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_count = count;
		cur_ftype = ftype[TYPE_W-1:0];
	endtask

	task automatic run_phase(input int count, input int ftype, input int n_items,
			input int send_idle, input int recv_stall, input int load_pct);
		in_tdata_t req;
		logic op;
		drain();
		configure(count, ftype);
		send_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
		for (int n = 0; n < n_items; n++) begin
			make_req(load_pct, op, req);
			send_req(op, req);
		end
	endtask

	initial begin
		in_tdata_t req;
		logic op;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		hold_off <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cur_count = int'(SYMBOL_COUNT_RESET);
		cur_ftype = FUNCTION_TYPE_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Overlapping functions, a non-function shadow, a range past the top of memory,
		// an empty range and an all-covering non-function entry.
		configure(8, FUNCTION_TYPE_RESET);
		load_slot(0, 32'h8000_0000, 32'h100, FUNCTION_TYPE_RESET);
		load_slot(1, 32'h8000_0080, 32'h100, FUNCTION_TYPE_RESET);
		load_slot(2, 32'h8000_0200, 32'h100, 8'h11);
		load_slot(3, 32'h8000_0200, 32'h80, FUNCTION_TYPE_RESET);
		load_slot(4, 32'hffff_ff00, 32'h200, FUNCTION_TYPE_RESET);
		load_slot(5, 32'h9000_0000, 32'h0, FUNCTION_TYPE_RESET);
		load_slot(6, 32'h0, 32'hffff_ffff, 8'hff);
		load_slot(7, 32'hffff_ffff, 32'hffff_ffff, FUNCTION_TYPE_RESET);
		trace_req(32'h0000_0013, 32'h8000_0000, 32'h8000_0004);
		trace_req({20'h00100, 5'd1, OPC_JAL}, 32'h8000_0010, 32'h8000_0180);
		trace_req({12'h000, 5'd15, 3'b000, 5'd1, OPC_JALR}, 32'h8000_0210, 32'h8000_0000);
		trace_req({12'h000, RET_PATTERN}, 32'h8000_0180, 32'h8000_0214);
		trace_req({12'hfff, RET_PATTERN}, 32'hffff_ffff, 32'h1234_5678);
		trace_req({12'h000, 5'd1, 3'b000, 5'd2, OPC_JALR}, 32'h9000_0000, 32'hffff_ffff);
		trace_req({25'h0, OPC_JAL}, 32'h0, 32'h8000_0100);
		trace_req({25'h1ff_ffff, OPC_JAL}, 32'h8000_0280, 32'h8000_01ff);
		trace_req(32'h0000_8063, 32'h8000_0000, 32'h8000_0100);
		trace_req(32'hffff_ffff, 32'h8000_0000, 32'h8000_0100);
		trace_req({12'h000, RET_PATTERN}, 32'h8000_0004, 32'h0000_0000);
		trace_req({12'h000, RET_PATTERN}, 32'h1000_0000, 32'h8000_007f);
		trace_req({12'h000, RET_PATTERN}, 32'h8000_00ff, 32'h8000_0080);

		// Every slot is written before any phase searches beyond the first eight.
		drain();
		for (int i = 0; i < SYMBOL_SLOTS_DEF; i++) begin
			make_req(100, op, req);
			req.entry_index = i[INDEX_W-1:0];
			send_req(OP_LOAD, req);
		end

		run_phase(16, FUNCTION_TYPE_RESET, 80, 0, 0, 25);
		run_phase(64, FUNCTION_TYPE_RESET, 60, 59, 0, 25);
		run_phase(3, 0, 60, 0, 59, 25);
		run_phase(256, 255, 30, 35, 35, 20);
		run_phase(511, FUNCTION_TYPE_RESET, 20, 0, 0, 20);
		run_phase(0, FUNCTION_TYPE_RESET, 20, 0, 0, 20);
		run_phase(12, $urandom_range(0, 255), 40, 35, 35, 25);

		// The result side holds off long enough for the queue to fill and stall the input.
		drain();
		configure(8, FUNCTION_TYPE_RESET);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
			for (int n = 0; n < 60; n++) begin
				make_req(20, op, req);
				send_req(op, req);
			end
		join

		drain();
		if (errors == 0 && pending == 0)
			$display("PASS call_return_symbol_tracer");
		else
			$display("FAIL call_return_symbol_tracer");
		$finish;
	end

endmodule
